FILE: rtl/bead_width_distributor_assert.svh
// Assertion macros shared by the bead width distributor RTL
`ifndef BEAD_WIDTH_DISTRIBUTOR_ASSERT_SVH
`define BEAD_WIDTH_DISTRIBUTOR_ASSERT_SVH

// Same-cycle implication, off during reset
`define BWD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bead width distributor: same-cycle check failed");

// Next-cycle implication, off during reset
`define BWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bead width distributor: next-cycle check failed");

`endif

FILE: rtl/bwd_pkg.sv
// ----------------------------------------------------------------------------
// bwd_pkg
// Field widths, reset constants and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package bwd_pkg;

  localparam int THICK_W = 20;
  localparam int COUNT_W = 7;
  localparam int NUM_W   = 6;
  localparam int BEAD_W  = 24;
  localparam int OPT_W   = 16;

  localparam logic [OPT_W-1:0] OPT_RESET = 16'd400;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic sub;
    logic step;
  } bwd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_last;
    logic out_free;
  } bwd_sts_t;

endpackage

FILE: rtl/bwd_in_if.sv
// ----------------------------------------------------------------------------
// bwd_in_if
// Input item channel: wall thickness and bead count with valid/ready.
// ----------------------------------------------------------------------------
interface bwd_in_if
  import bwd_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [THICK_W-1:0] thickness;
  logic [COUNT_W-1:0] num_beads;

  modport source (output valid, output thickness, output num_beads, input ready);
  modport sink   (input valid, input thickness, input num_beads, output ready);
endinterface

FILE: rtl/bwd_out_if.sv
// ----------------------------------------------------------------------------
// bwd_out_if
// Result item channel: one bead description per item with valid/ready.
// ----------------------------------------------------------------------------
interface bwd_out_if
  import bwd_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [NUM_W-1:0]         bead_number;
  logic signed [BEAD_W-1:0] bead_width;
  logic signed [BEAD_W-1:0] center_location;
  logic                     has_bead;
  logic [THICK_W-1:0]       unfilled;
  logic                     last;

  modport source (output valid, output bead_number, output bead_width,
                  output center_location, output has_bead, output unfilled,
                  output last, input ready);
  modport sink   (input valid, input bead_number, input bead_width,
                  input center_location, input has_bead, input unfilled,
                  input last, output ready);
endinterface

FILE: rtl/bwd_ctrl.sv
// ----------------------------------------------------------------------------
// bwd_ctrl
// Sequencer: take an item, form the middle width, then step one bead a cycle while the output has room.
// ----------------------------------------------------------------------------
`include "bead_width_distributor_assert.svh"

module bwd_ctrl
  import bwd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output bwd_cmd_t cmd,
  input  bwd_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SUB,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // Decode commands from the current state
  always_comb begin
    cmd         = '0;
    cmd.capture = (state_r == S_IDLE) && in_valid && in_ready_r;
    cmd.mul     = (state_r == S_MUL);
    cmd.sub     = (state_r == S_SUB);
    cmd.step    = (state_r == S_EMIT) && sts.out_free;
  end

  // Next state
  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt    = S_MUL;
          in_ready_nxt = 1'b0;
        end
      end
      S_MUL: state_nxt = S_SUB;
      S_SUB: state_nxt = S_EMIT;
      S_EMIT: begin
        if (cmd.step && sts.is_last) begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

  `BWD_ASSERT_SAME(a_step_needs_room, clk, rst_n, cmd.step, sts.out_free)
  `BWD_ASSERT_NEXT(a_last_returns_idle, clk, rst_n, cmd.step && sts.is_last,
                   state_r == S_IDLE && in_ready)
  `BWD_ASSERT_NEXT(a_capture_blocks_input, clk, rst_n, cmd.capture, !in_ready && !cmd.capture)

endmodule

FILE: rtl/bwd_dpath.sv
// ----------------------------------------------------------------------------
// bwd_dpath
// Datapath: optimal width register, middle width calculation, location
// accumulator and the result output register.
// ----------------------------------------------------------------------------
module bwd_dpath
  import bwd_pkg::*;
#(
  parameter int MAX_BEADS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [OPT_W-1:0]         cfg_wdata,
  input  logic [THICK_W-1:0]       in_thickness,
  input  logic [COUNT_W-1:0]       in_num_beads,
  input  bwd_cmd_t                 cmd,
  output bwd_sts_t                 sts,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [NUM_W-1:0]         out_bead_number,
  output logic signed [BEAD_W-1:0] out_bead_width,
  output logic signed [BEAD_W-1:0] out_center_location,
  output logic                     out_has_bead,
  output logic [THICK_W-1:0]       out_unfilled,
  output logic                     out_last
);

  localparam int CW = $clog2(MAX_BEADS + 1);
  localparam int IW = $clog2(MAX_BEADS);
  localparam int SW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int PW = CW + OPT_W;
  localparam int DW = ((PW > THICK_W) ? PW : THICK_W) + 1;

  logic [OPT_W-1:0]         opt_width_r;
  logic [THICK_W-1:0]       thick_r;
  logic [CW-1:0]            n_r;
  logic [PW-1:0]            prod_r;
  logic signed [DW-1:0]     mid_r;
  logic [IW-1:0]            idx_r;
  logic signed [DW-1:0]     prev_r;
  logic [BEAD_W-1:0]        loc_r;
  logic                     out_valid_r;
  logic [NUM_W-1:0]         out_num_r;
  logic signed [BEAD_W-1:0] out_width_r;
  logic signed [BEAD_W-1:0] out_loc_r;
  logic                     out_has_r;
  logic [THICK_W-1:0]       out_left_r;
  logic                     out_last_r;

  logic [SW-1:0]        cnt_ext;
  logic [CW-1:0]        n_sat;
  logic [CW-1:0]        mcnt;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] mid_nxt;
  logic [CW-1:0]        idx_ext;
  logic [CW-1:0]        n_half;
  logic                 is_mid;
  logic signed [DW-1:0] cur;
  logic signed [DW:0]   pair_sum;
  logic signed [DW:0]   pair_half;
  logic [BEAD_W-1:0]    loc_nxt;
  logic                 n_zero;
  logic                 is_last;

  // Saturate the count to the supported bead range
  assign cnt_ext = SW'(in_num_beads);
  assign n_sat   = (cnt_ext > SW'(MAX_BEADS)) ? CW'(MAX_BEADS) : CW'(cnt_ext);

  // Multiplier operand: count minus one (odd) or count minus two (even)
  assign mcnt = n_r - CW'(2) + CW'(n_r[0]);

  // Middle width, halved toward zero for an even count
  assign diff    = $signed(DW'(thick_r)) - $signed(DW'(prod_r));
  assign mid_nxt = n_r[0] ? diff : ((diff + $signed(DW'(diff[DW-1]))) >>> 1);

  // Pick the width of the current bead
  assign idx_ext = CW'(idx_r);
  assign n_half  = n_r >> 1;
  assign is_mid  = n_r[0] ? (idx_ext == n_half)
                          : ((idx_ext == n_half) || (idx_ext + CW'(1) == n_half));
  assign cur     = is_mid ? mid_r : $signed(DW'(opt_width_r));

  // Advance the center location by half the neighbor sum, toward zero
  assign pair_sum  = (DW+1)'(cur) + (DW+1)'(prev_r);
  assign pair_half = (pair_sum + $signed((DW+1)'(pair_sum[DW]))) >>> 1;
  assign loc_nxt   = loc_r + BEAD_W'(pair_half);

  assign n_zero  = (n_r == '0);
  assign is_last = n_zero || (idx_ext == n_r - CW'(1));

  assign sts.is_last  = is_last;
  assign sts.out_free = !out_valid_r || out_ready;

  // Control registers: configuration and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opt_width_r <= OPT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        opt_width_r <= cfg_wdata;
      end
      if (cmd.step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      thick_r <= in_thickness;
      n_r     <= n_sat;
      idx_r   <= '0;
      prev_r  <= '0;
      loc_r   <= '0;
    end
    if (cmd.mul) begin
      prod_r <= PW'(mcnt) * PW'(opt_width_r);
    end
    if (cmd.sub) begin
      mid_r <= mid_nxt;
    end
    if (cmd.step) begin
      idx_r  <= idx_r + IW'(1);
      prev_r <= cur;
      loc_r  <= loc_nxt;
      out_last_r <= is_last;
      if (n_zero) begin
        out_num_r   <= '0;
        out_width_r <= '0;
        out_loc_r   <= '0;
        out_has_r   <= 1'b0;
        out_left_r  <= thick_r;
      end else begin
        out_num_r   <= NUM_W'(idx_r);
        out_width_r <= BEAD_W'(cur);
        out_loc_r   <= loc_nxt;
        out_has_r   <= 1'b1;
        out_left_r  <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bead_number     = out_num_r;
  assign out_bead_width      = out_width_r;
  assign out_center_location = out_loc_r;
  assign out_has_bead        = out_has_r;
  assign out_unfilled        = out_left_r;
  assign out_last            = out_last_r;

endmodule

FILE: rtl/bead_width_distributor.sv
// ----------------------------------------------------------------------------
// bead_width_distributor
// Splits a wall thickness over a number of beads, one result item per bead.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one item (thickness, num_beads); out_chan returns one
//   item per bead from the outside inward, last set on the final one. A count
//   of zero returns a single item with has_bead low and the thickness as
//   unfilled. Counts above MAX_BEADS are saturated.
//   cfg_we/cfg_wdata write the outer bead width (reset 400); write only while idle.
// Sequence:
//   After an item is accepted, the middle width is formed by a multiply and
//   then a subtract, then the sequencer emits one bead per cycle while the
//   output register is free. The next item is accepted as soon as the last
//   result sits in the output register, even if it has not been taken.
// Reset and stall:
//   Synchronous active-low reset returns the sequencer to idle, drops any
//   pending result and restores the outer bead width. When out_chan.ready is
//   low the output register holds its item and the bead sequencer waits.
// ----------------------------------------------------------------------------
module bead_width_distributor
  import bwd_pkg::*;
#(
  parameter int MAX_BEADS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [OPT_W-1:0] cfg_wdata,
  bwd_in_if.sink           in_chan,
  bwd_out_if.source        out_chan
);

  bwd_cmd_t cmd;
  bwd_sts_t sts;

  // Sequencer
  bwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Arithmetic and output register
  bwd_dpath #(
    .MAX_BEADS (MAX_BEADS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_thickness        (in_chan.thickness),
    .in_num_beads        (in_chan.num_beads),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_bead_number     (out_chan.bead_number),
    .out_bead_width      (out_chan.bead_width),
    .out_center_location (out_chan.center_location),
    .out_has_bead        (out_chan.has_bead),
    .out_unfilled        (out_chan.unfilled),
    .out_last            (out_chan.last)
  );

endmodule

FILE: tb/sv/bead_width_distributor_tb.sv
// ----------------------------------------------------------------------------
// bead_width_distributor_tb
// Drives wall items (thickness, bead count) into the distributor and checks
// every bead item against a local prediction of widths and center locations.
// Directed walls cover count zero, odd and even counts, saturation, negative
// widths and extreme optimal widths; random walls follow under several widths,
// mostly with random idle cycles on both channels, and one long output hold-off.
// ----------------------------------------------------------------------------
module bead_width_distributor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bwd_pkg::*;

  localparam int BEADS_MAX   = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_LEN    = 300;
  localparam int SETTLE      = 8;

  typedef struct {
    logic [NUM_W-1:0]         bead_number;
    logic signed [BEAD_W-1:0] bead_width;
    logic signed [BEAD_W-1:0] center_location;
    logic                     has_bead;
    logic [THICK_W-1:0]       unfilled;
    logic                     last;
  } bead_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [OPT_W-1:0] cfg_wdata;

  bwd_in_if  in_chan ();
  bwd_out_if out_chan ();

  bead_t            pending_beads[$];
  logic [OPT_W-1:0] opt_width;
  bit               gaps_on;
  int               hold_cycles = 0;
  int               fault_count = 0;
  int               quiet_cycles = 0;

  bead_width_distributor #(
    .MAX_BEADS(BEADS_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expand one wall into its bead items, outside inward
  function automatic void predict_beads(input logic [THICK_W-1:0] thick,
                                        input logic [COUNT_W-1:0] cnt);
    longint n;
    longint t;
    longint w;
    longint cur;
    longint prev;
    longint loc;
    bead_t  b;
    n    = cnt;
    t    = thick;
    w    = opt_width;
    prev = 0;
    loc  = 0;
    if (n > BEADS_MAX) n = BEADS_MAX;
    // No bead: the whole thickness is left over
    if (n == 0) begin
      b.bead_number     = '0;
      b.bead_width      = '0;
      b.center_location = '0;
      b.has_bead        = 1'b0;
      b.unfilled        = thick;
      b.last            = 1'b1;
      pending_beads.push_back(b);
      return;
    end
    for (longint i = 0; i < n; i++) begin
      // Outer beads take the optimal width, the middle one or pair the rest
      cur = w;
      if (n % 2 == 1) begin
        if (i == n / 2) cur = t - (n - 1) * w;
      end else if (i == n / 2 - 1 || i == n / 2) begin
        cur = (t - (n - 2) * w) / 2;
      end
      if (i == 0) loc = cur / 2;
      else loc = loc + (cur + prev) / 2;
      prev = cur;
      b.bead_number     = i[NUM_W-1:0];
      b.bead_width      = cur[BEAD_W-1:0];
      b.center_location = loc[BEAD_W-1:0];
      b.has_bead        = 1'b1;
      b.unfilled        = '0;
      b.last            = (i == n - 1);
      pending_beads.push_back(b);
    end
  endfunction

  // Offer one wall item and hold it until accepted; valid stays high after
  task automatic send_wall(input logic [THICK_W-1:0] thick,
                           input logic [COUNT_W-1:0] cnt);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.thickness <= thick;
    in_chan.num_beads <= cnt;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    predict_beads(thick, cnt);
  endtask

  // Drop valid and wait until every predicted bead has come back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_beads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_opt_width(input logic [OPT_W-1:0] width);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_we    <= 1'b0;
    opt_width = width;
  endtask

  // Mostly small counts, some up to the cap, a few beyond it
  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 6) return COUNT_W'($urandom_range(0, 8));
    if (r <= 8) return COUNT_W'($urandom_range(9, BEADS_MAX));
    return COUNT_W'($urandom_range(BEADS_MAX + 1, 127));
  endfunction

  // Half the thicknesses near count times width, the rest small or anything
  function automatic logic [THICK_W-1:0] pick_thickness(input logic [COUNT_W-1:0] cnt);
    longint w;
    longint guess;
    w = opt_width;
    case ($urandom_range(0, 3))
      0: return THICK_W'($urandom);
      1: return THICK_W'($urandom_range(0, 4095));
      default: begin
        guess = longint'(cnt) * w + longint'($urandom_range(0, 2 * w)) - w;
        if (guess < 0) guess = 0;
        if (guess > (1 << THICK_W) - 1) guess = (1 << THICK_W) - 1;
        return guess[THICK_W-1:0];
      end
    endcase
  endfunction

  task automatic test_zero_count();
    send_wall(20'd0, 7'd0);
    send_wall(20'hFFFFF, 7'd0);
  endtask

  task automatic test_odd_even();
    send_wall(20'd400, 7'd1);
    send_wall(20'd800, 7'd2);
    send_wall(20'd1201, 7'd2);
    send_wall(20'd1200, 7'd3);
    send_wall(20'd1000, 7'd4);
  endtask

  task automatic test_saturation();
    send_wall(20'hFFFFF, 7'd64);
    send_wall(20'd5000, 7'd65);
    send_wall(20'hFFFFF, 7'd127);
  endtask

  task automatic test_negative_widths();
    send_wall(20'd0, 7'd3);
    send_wall(20'd1, 7'd4);
    send_wall(20'd0, 7'd64);
  endtask

  task automatic test_width_extremes();
    set_opt_width(16'd0);
    send_wall(20'd1000, 7'd5);
    send_wall(20'hFFFFF, 7'd64);
    set_opt_width(16'hFFFF);
    send_wall(20'd0, 7'd63);
    send_wall(20'hFFFFF, 7'd64);
    send_wall(20'd70000, 7'd2);
    set_opt_width(16'd1);
    send_wall(20'd7, 7'd3);
    send_wall(20'd0, 7'd2);
  endtask

  // Hold the output off so the block fills and stalls its input
  task automatic test_input_backpressure();
    logic [COUNT_W-1:0] cnt;
    set_opt_width(OPT_RESET);
    hold_cycles = HOLD_LEN;
    gaps_on = 1'b0;
    repeat (20) begin
      cnt = COUNT_W'($urandom_range(1, 6));
      send_wall(pick_thickness(cnt), cnt);
    end
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_walls(input logic [OPT_W-1:0] width, input int items,
                                   input bit gaps);
    logic [COUNT_W-1:0] cnt;
    set_opt_width(width);
    gaps_on = gaps;
    repeat (items) begin
      cnt = pick_count();
      send_wall(pick_thickness(cnt), cnt);
    end
  endtask

  // Compare each accepted bead item with the oldest prediction
  always @(posedge clk) begin
    bead_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_beads.size() == 0) begin
        $error("unexpected result item: bead_number %0d", out_chan.bead_number);
        fault_count++;
      end else begin
        want = pending_beads.pop_front();
        if (out_chan.bead_number !== want.bead_number) begin
          $error("bead_number: expected %0d, actual %0d", want.bead_number,
                 out_chan.bead_number);
          fault_count++;
        end
        if (out_chan.bead_width !== want.bead_width) begin
          $error("bead_width: expected %0d, actual %0d", want.bead_width,
                 out_chan.bead_width);
          fault_count++;
        end
        if (out_chan.center_location !== want.center_location) begin
          $error("center_location: expected %0d, actual %0d", want.center_location,
                 out_chan.center_location);
          fault_count++;
        end
        if (out_chan.has_bead !== want.has_bead) begin
          $error("has_bead: expected %0b, actual %0b", want.has_bead, out_chan.has_bead);
          fault_count++;
        end
        if (out_chan.unfilled !== want.unfilled) begin
          $error("unfilled: expected %0d, actual %0d", want.unfilled,
                 out_chan.unfilled);
          fault_count++;
        end
        if (out_chan.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_chan.last);
          fault_count++;
        end
      end
    end
  end

  // Receiver: random stalls per item, plus one long hold on request
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_chan.valid     <= 1'b0;
    in_chan.thickness <= '0;
    in_chan.num_beads <= '0;
    opt_width = OPT_RESET;
    gaps_on   = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_count();
    test_odd_even();
    test_saturation();
    test_negative_widths();
    test_width_extremes();
    test_input_backpressure();
    test_random_walls(OPT_RESET, 110, 1'b1);
    test_random_walls(OPT_W'($urandom_range(1, 65535)), 110, 1'b0);
    test_random_walls(16'hFFFF, 110, 1'b1);
    test_random_walls(16'd1, 110, 1'b1);
    drain_results();

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
